// ===== sv/ccb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the clipped color-keyed cursor blit.
// Holds item types, coordinate type and register indexes; depends on nothing.
package ccb_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int OUT_ADDR_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEFT_EDGE     = 3'd0,
    REG_TOP_EDGE      = 3'd1,
    REG_CURSOR_WIDTH  = 3'd2,
    REG_CURSOR_HEIGHT = 3'd3,
    REG_VIEW_WIDTH    = 3'd4,
    REG_VIEW_HEIGHT   = 3'd5,
    REG_LINE_STRIDE   = 3'd6,
    REG_BASE_ADDRESS  = 3'd7
  } cfg_reg_t;

  // signed screen coordinate, wide enough for edge plus cursor size
  typedef logic signed [14:0] coord_t;

  typedef struct packed {
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic                     write_enable;
    logic [OUT_ADDR_BITS-1:0] write_address;
    logic [7:0]               write_data;
    logic                     image_done;
  } out_item_t;

  typedef struct packed {
    logic   active;
    coord_t x0;
    coord_t x1;
    coord_t y0;
    coord_t y1;
  } clip_t;

endpackage

// ===== sv/ccb_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one item per handshake.
// The payload type is set by the instantiating level.
interface ccb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ccb_clip.sv =====
`timescale 1ns / 1ps
// Clip rectangle of the cursor against the view, from the configuration.
// Depends on ccb_pkg.
module ccb_clip (
  input  ccb_pkg::coord_t xs,
  input  ccb_pkg::coord_t ys,
  input  ccb_pkg::coord_t cw,
  input  ccb_pkg::coord_t ch,
  input  ccb_pkg::coord_t vw,
  input  ccb_pkg::coord_t vh,
  output ccb_pkg::clip_t  clip
);
  ccb_pkg::coord_t xe;
  ccb_pkg::coord_t ye;
  ccb_pkg::coord_t vx1;
  ccb_pkg::coord_t vy1;
  logic            draw;

  always_comb begin
    xe   = xs + cw - ccb_pkg::coord_t'(1);
    ye   = ys + ch - ccb_pkg::coord_t'(1);
    vx1  = vw - ccb_pkg::coord_t'(1);
    vy1  = vh - ccb_pkg::coord_t'(1);
    draw = !((xs >= vw) || (ys >= vh) || (xe <= 0) || (ye <= 0));
    clip.x0 = (xs < 0) ? ccb_pkg::coord_t'(0) : xs;
    clip.y0 = (ys < 0) ? ccb_pkg::coord_t'(0) : ys;
    clip.x1 = (xe < vx1) ? xe : vx1;
    clip.y1 = (ye < vy1) ? ye : vy1;
    // skip the image when the clipped span is a single pixel or less
    clip.active = draw && (clip.x1 > clip.x0) && (clip.y1 > clip.y0);
  end
endmodule

// ===== sv/clipped_color_keyed_cursor_blit_top.sv =====
`timescale 1ns / 1ps
// Clipped color-keyed cursor blit: one frame buffer write per cursor byte.
// Depends on ccb_pkg, ccb_stream_if and ccb_clip.
//
// The block takes one cursor image byte per clock in raster order and returns one write
// request per byte through a stage register and then a result register; the rate is one
// item per cycle, and it holds while the result side keeps taking items.
// The image position is kept by an internal column and row counter that wraps after the
// last byte, so image_done marks the end of each image. A write is enabled only for a
// nonzero byte inside the clipped cursor rectangle; disabled writes carry address zero.
// Program the registers only while no item is in flight.
module clipped_color_keyed_cursor_blit_top #(
  parameter int MAX_CURSOR_WIDTH  = 64,
  parameter int MAX_CURSOR_HEIGHT = 64,
  parameter int ADDRESS_BITS      = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write_enable,
  input  logic [ccb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ccb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  ccb_stream_if.sink                         in_stream,
  ccb_stream_if.source                       out_stream
);
  localparam int CXW = (MAX_CURSOR_WIDTH > 1) ? $clog2(MAX_CURSOR_WIDTH) : 1;
  localparam int CYW = (MAX_CURSOR_HEIGHT > 1) ? $clog2(MAX_CURSOR_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_CURSOR_WIDTH + 1);
  localparam int HW  = $clog2(MAX_CURSOR_HEIGHT + 1);
  localparam int WSZ = (WW > 7) ? WW : 7;
  localparam int HSZ = (HW > 7) ? HW : 7;

  logic signed [12:0] left_edge_r;
  logic signed [12:0] top_edge_r;
  logic [6:0]         cursor_width_r;
  logic [6:0]         cursor_height_r;
  logic [12:0]        view_width_r;
  logic [12:0]        view_height_r;
  logic [13:0]        line_stride_r;
  logic [31:0]        base_address_r;

  logic [CXW-1:0] col_r, col_nxt;
  logic [CYW-1:0] row_r, row_nxt;

  logic           s1_valid_r;
  logic [7:0]     s1_pixel_r;
  logic [CXW-1:0] s1_col_r;
  logic [CYW-1:0] s1_row_r;
  logic           s1_done_r;

  logic               out_valid_r;
  ccb_pkg::out_item_t out_item_r, out_item_nxt;

  logic [WSZ-1:0] w_ext, w_sz;
  logic [HSZ-1:0] h_ext, h_sz;
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;
  logic           last_col, last_row;
  logic           in_fire, s1_adv;

  ccb_pkg::clip_t  clip;
  ccb_pkg::coord_t sx, sy;
  logic            en;
  logic [26:0]     prod;
  logic [ADDRESS_BITS-1:0] addr;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_edge_r     <= '0;
      top_edge_r      <= '0;
      cursor_width_r  <= 7'd1;
      cursor_height_r <= 7'd1;
      view_width_r    <= 13'd1;
      view_height_r   <= 13'd1;
      line_stride_r   <= 14'd1;
      base_address_r  <= '0;
    end else if (cfg_write_enable) begin
      case (ccb_pkg::cfg_reg_t'(cfg_index))
        ccb_pkg::REG_LEFT_EDGE:     left_edge_r     <= cfg_data[12:0];
        ccb_pkg::REG_TOP_EDGE:      top_edge_r      <= cfg_data[12:0];
        ccb_pkg::REG_CURSOR_WIDTH:  cursor_width_r  <= cfg_data[6:0];
        ccb_pkg::REG_CURSOR_HEIGHT: cursor_height_r <= cfg_data[6:0];
        ccb_pkg::REG_VIEW_WIDTH:    view_width_r    <= cfg_data[12:0];
        ccb_pkg::REG_VIEW_HEIGHT:   view_height_r   <= cfg_data[12:0];
        ccb_pkg::REG_LINE_STRIDE:   line_stride_r   <= cfg_data[13:0];
        ccb_pkg::REG_BASE_ADDRESS:  base_address_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // clamp cursor size to 1..max
  always_comb begin
    w_ext = WSZ'(cursor_width_r);
    h_ext = HSZ'(cursor_height_r);
    if (w_ext == '0) begin
      w_sz = WSZ'(1);
    end else if (w_ext > WSZ'(MAX_CURSOR_WIDTH)) begin
      w_sz = WSZ'(MAX_CURSOR_WIDTH);
    end else begin
      w_sz = w_ext;
    end
    if (h_ext == '0) begin
      h_sz = HSZ'(1);
    end else if (h_ext > HSZ'(MAX_CURSOR_HEIGHT)) begin
      h_sz = HSZ'(MAX_CURSOR_HEIGHT);
    end else begin
      h_sz = h_ext;
    end
    w = WW'(w_sz);
    h = HW'(h_sz);
  end

  ccb_clip u_clip (
    .xs   (ccb_pkg::coord_t'(left_edge_r)),
    .ys   (ccb_pkg::coord_t'(top_edge_r)),
    .cw   (ccb_pkg::coord_t'(w)),
    .ch   (ccb_pkg::coord_t'(h)),
    .vw   (ccb_pkg::coord_t'(view_width_r)),
    .vh   (ccb_pkg::coord_t'(view_height_r)),
    .clip (clip)
  );

  // handshake
  assign s1_adv          = !out_valid_r || out_stream.ready;
  assign in_stream.ready = !s1_valid_r || s1_adv;
  assign in_fire         = in_stream.valid && in_stream.ready;

  // raster position counters
  always_comb begin
    last_col = (WW'(col_r) + WW'(1)) >= w;
    last_row = (HW'(row_r) + HW'(1)) >= h;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CYW'(1);
      end else begin
        col_nxt = col_r + CXW'(1);
      end
    end
  end

  // pixel test and address
  always_comb begin
    sx   = ccb_pkg::coord_t'(left_edge_r) + ccb_pkg::coord_t'(s1_col_r);
    sy   = ccb_pkg::coord_t'(top_edge_r) + ccb_pkg::coord_t'(s1_row_r);
    en   = clip.active && (sx >= clip.x0) && (sx <= clip.x1) &&
           (sy >= clip.y0) && (sy <= clip.y1) && (s1_pixel_r != 8'd0);
    prod = 27'(line_stride_r) * 27'(sy[12:0]);
    addr = ADDRESS_BITS'(base_address_r) + ADDRESS_BITS'(prod) +
           ADDRESS_BITS'(sx[12:0]);
    out_item_nxt.write_enable  = en;
    out_item_nxt.write_address = en ? ccb_pkg::OUT_ADDR_BITS'(addr) : '0;
    out_item_nxt.write_data    = s1_pixel_r;
    out_item_nxt.image_done    = s1_done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_stream.ready) begin
        s1_valid_r <= in_stream.valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r <= in_stream.payload.pixel;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_done_r  <= last_col && last_row;
    end
    if (s1_valid_r && s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_stream.valid   = out_valid_r;
  assign out_stream.payload = out_item_r;

endmodule
